/* design/animated_test_pattern_generator_top_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the animated test pattern generator
// clocked property checks, with and without a reset qualifier
// ----------------------------------------------------------------------------
`ifndef ANIMATED_TEST_PATTERN_GENERATOR_TOP_MACROS_SVH
`define ANIMATED_TEST_PATTERN_GENERATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every rising edge outside reset
`define ATPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ATPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ATPG_ASSERT(lbl, clk, rst_n, prop, msg)
`define ATPG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/atpg_pkg.sv */
// ----------------------------------------------------------------------------
// atpg_pkg
// shared types and constants of the animated test pattern generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atpg_pkg;

    // width of the frame counter and of the values reduced against constants
    localparam int NUM_W = 24;

    // field widths
    localparam int PIX_X_W = 9;
    localparam int PIX_Y_W = 8;
    localparam int BOX_W_W = 9;
    localparam int BOX_H_W = 8;

    // register map, indexed by paddr bit 2
    localparam int  ADDR_W         = 3;
    localparam logic REG_BOX_WIDTH  = 1'b0;
    localparam logic REG_BOX_HEIGHT = 1'b1;

    localparam logic [BOX_W_W-1:0] BOX_WIDTH_RST  = 9'd40;
    localparam logic [BOX_H_W-1:0] BOX_HEIGHT_RST = 8'd30;

    // color constants
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] CHAN_FULL    = 8'hFF;
    localparam logic [7:0] CHAN_ZERO    = 8'h00;

    typedef enum logic [1:0] {
        PAT_GRADIENT = 2'd0,
        PAT_XOR      = 2'd1,
        PAT_BOX      = 2'd2
    } t_pattern;

    // load enables of the three stages inside a reduction unit
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

`default_nettype wire

/* design/atpg_modred.sv */
// ----------------------------------------------------------------------------
// atpg_modred
// pipelined remainder of a 24-bit value by a constant divisor
// reciprocal multiply, multiply back, one compare and subtract
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atpg_modred #(
    parameter int DIVISOR = 3
) (
    input  wire                            i_clk,
    input  wire atpg_pkg::t_stage_en       i_en,
    input  wire [atpg_pkg::NUM_W-1:0]      i_num,
    output logic [$clog2(DIVISOR)-1:0]     o_rem
);

    localparam int NW    = atpg_pkg::NUM_W;
    localparam int REM_W = $clog2(DIVISOR);
    localparam int RAW_W = $clog2(2 * DIVISOR);

    // floor(2^NW / DIVISOR): quotient estimate is low by at most one
    localparam logic [NW-1:0]    RECIP   = NW'((64'd1 << NW) / DIVISOR);
    localparam logic [NW-1:0]    DIV_C   = NW'(DIVISOR);
    localparam logic [RAW_W-1:0] DIV_RAW = RAW_W'(DIVISOR);

    logic [NW-1:0]    r_quo;
    logic [NW-1:0]    r_num;
    logic [RAW_W-1:0] r_raw;
    logic [REM_W-1:0] r_rem;

    logic [2*NW-1:0]  quo_prod;
    logic [2*NW-1:0]  back_prod;
    logic [NW-1:0]    diff;
    logic [RAW_W-1:0] n_rem;

    // stage 2: quotient estimate
    assign quo_prod = i_num * RECIP;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_quo <= quo_prod[2*NW-1:NW];
            r_num <= i_num;
        end
    end

    // stage 3: raw remainder, below twice the divisor
    assign back_prod = r_quo * DIV_C;
    assign diff      = r_num - back_prod[NW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_raw <= diff[RAW_W-1:0];
        end
    end

    // stage 4: final correction
    assign n_rem = (r_raw >= DIV_RAW) ? (r_raw - DIV_RAW) : r_raw;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_rem <= n_rem[REM_W-1:0];
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

/* design/animated_test_pattern_generator_top.sv */
// ----------------------------------------------------------------------------
// animated_test_pattern_generator_top
// per-pixel RGBA source cycling through gradient, xor and bouncing box
// ----------------------------------------------------------------------------
// The generator takes one pixel word (frame number, x, y) per clock and
// returns its RGBA word and pattern index at a sustained rate of one pixel
// per clock while i_stall is low. The pipeline is an input stage, the
// three-stage reduction units (reciprocal multiply, multiply back, correct)
// that work out frame mod (3 * FRAMES_PER_PATTERN), frame mod
// (2 * SCREEN_WIDTH) and (3 * frame / 4) mod (2 * SCREEN_HEIGHT), a fold
// stage and an output stage. Stalls hold only the full stages, so empty
// slots are squeezed out. Box size registers sit at byte addresses 0 and 4
// and are meant to be written while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "animated_test_pattern_generator_top_macros.svh"

module animated_test_pattern_generator_top #(
    parameter int SCREEN_WIDTH       = 320,
    parameter int SCREEN_HEIGHT      = 200,
    parameter int FRAMES_PER_PATTERN = 90
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // pixel input
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire [atpg_pkg::NUM_W-1:0]        i_frame_number,
    input  wire [atpg_pkg::PIX_X_W-1:0]      i_pixel_x,
    input  wire [atpg_pkg::PIX_Y_W-1:0]      i_pixel_y,
    // color output
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [31:0]                      o_rgba_word,
    output logic [1:0]                       o_pattern_index,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [atpg_pkg::ADDR_W-1:0]       paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int NS    = 6;
    localparam int NW    = atpg_pkg::NUM_W;
    localparam int XW    = atpg_pkg::PIX_X_W;
    localparam int YW    = atpg_pkg::PIX_Y_W;
    localparam int BWW   = atpg_pkg::BOX_W_W;
    localparam int BHW   = atpg_pkg::BOX_H_W;

    localparam int DIV_P = 3 * FRAMES_PER_PATTERN;
    localparam int DIV_X = 2 * SCREEN_WIDTH;
    localparam int DIV_Y = 2 * SCREEN_HEIGHT;
    localparam int PR_W  = $clog2(DIV_P);
    localparam int XR_W  = $clog2(DIV_X);
    localparam int YR_W  = $clog2(DIV_Y);
    localparam int BX_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int BY_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int SX_W  = ((BX_W > XW) ? BX_W : XW) + 1;
    localparam int SY_W  = ((BY_W > YW) ? BY_W : YW) + 1;

    localparam logic [PR_W-1:0]  PAT_ONE  = PR_W'(FRAMES_PER_PATTERN);
    localparam logic [PR_W-1:0]  PAT_TWO  = PR_W'(2 * FRAMES_PER_PATTERN);
    localparam logic [XR_W:0]    X_SIZE   = (XR_W + 1)'(SCREEN_WIDTH);
    localparam logic [XR_W:0]    X_TWICE  = (XR_W + 1)'(DIV_X);
    localparam logic [YR_W:0]    Y_SIZE   = (YR_W + 1)'(SCREEN_HEIGHT);
    localparam logic [YR_W:0]    Y_TWICE  = (YR_W + 1)'(DIV_Y);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [BWW-1:0] r_box_width;
    logic [BHW-1:0] r_box_height;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width  <= atpg_pkg::BOX_WIDTH_RST;
            r_box_height <= atpg_pkg::BOX_HEIGHT_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                atpg_pkg::REG_BOX_WIDTH:  r_box_width  <= pwdata[BWW-1:0];
                atpg_pkg::REG_BOX_HEIGHT: r_box_height <= pwdata[BHW-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            atpg_pkg::REG_BOX_WIDTH:  prdata = {{(32 - BWW){1'b0}}, r_box_width};
            atpg_pkg::REG_BOX_HEIGHT: prdata = {{(32 - BHW){1'b0}}, r_box_height};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [NS-1:0] r_valid;
    logic [NS-1:0] rdy;
    atpg_pkg::t_stage_en unit_en;

    always_comb begin
        rdy[NS-1] = !r_valid[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    assign o_stall    = !rdy[0];
    assign o_valid    = r_valid[NS-1];
    assign unit_en.s2 = rdy[1];
    assign unit_en.s3 = rdy[2];
    assign unit_en.s4 = rdy[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: capture word, form 3*frame/4
    // ------------------------------------------------------------------
    logic [NW-1:0] r1_f;
    logic [NW-1:0] r1_fy;
    logic [XW-1:0] r1_x;
    logic [YW-1:0] r1_y;
    logic [NW+1:0] triple;

    assign triple = {2'b00, i_frame_number} + {1'b0, i_frame_number, 1'b0};

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_f  <= i_frame_number;
            r1_fy <= triple[NW+1:2];
            r1_x  <= i_pixel_x;
            r1_y  <= i_pixel_y;
        end
    end

    // ------------------------------------------------------------------
    // stages 2 to 4: constant remainders
    // ------------------------------------------------------------------
    logic [PR_W-1:0] rem_p;
    logic [XR_W-1:0] rem_x;
    logic [YR_W-1:0] rem_y;

    atpg_modred #(.DIVISOR(DIV_P)) u_rem_pat (
        .i_clk (i_clk),
        .i_en  (unit_en),
        .i_num (r1_f),
        .o_rem (rem_p)
    );

    atpg_modred #(.DIVISOR(DIV_X)) u_rem_x (
        .i_clk (i_clk),
        .i_en  (unit_en),
        .i_num (r1_f),
        .o_rem (rem_x)
    );

    atpg_modred #(.DIVISOR(DIV_Y)) u_rem_y (
        .i_clk (i_clk),
        .i_en  (unit_en),
        .i_num (r1_fy),
        .o_rem (rem_y)
    );

    // pixel and low frame bits ride alongside the reduction units
    logic [XW-1:0] r2_x, r3_x, r4_x;
    logic [YW-1:0] r2_y, r3_y, r4_y;
    logic [8:0]    r2_f9, r3_f9, r4_f9;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_f9 <= r1_f[8:0];
        end
        if (rdy[2]) begin
            r3_x  <= r2_x;
            r3_y  <= r2_y;
            r3_f9 <= r2_f9;
        end
        if (rdy[3]) begin
            r4_x  <= r3_x;
            r4_y  <= r3_y;
            r4_f9 <= r3_f9;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: pattern select and box corner fold
    // ------------------------------------------------------------------
    atpg_pkg::t_pattern r5_pat;
    atpg_pkg::t_pattern n_pat;
    logic [BX_W-1:0]    r5_bx;
    logic [BY_W-1:0]    r5_by;
    logic [XW-1:0]      r5_x;
    logic [YW-1:0]      r5_y;
    logic [8:0]         r5_f9;
    logic [XR_W:0]      rx_ext;
    logic [YR_W:0]      ry_ext;
    logic [XR_W:0]      n_bx;
    logic [YR_W:0]      n_by;

    always_comb begin
        if (rem_p >= PAT_TWO) begin
            n_pat = atpg_pkg::PAT_BOX;
        end else if (rem_p >= PAT_ONE) begin
            n_pat = atpg_pkg::PAT_XOR;
        end else begin
            n_pat = atpg_pkg::PAT_GRADIENT;
        end
    end

    // bounce back off the far edge
    assign rx_ext = {1'b0, rem_x};
    assign ry_ext = {1'b0, rem_y};
    assign n_bx   = (rx_ext >= X_SIZE) ? (X_TWICE - rx_ext) : rx_ext;
    assign n_by   = (ry_ext >= Y_SIZE) ? (Y_TWICE - ry_ext) : ry_ext;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r5_pat <= n_pat;
            r5_bx  <= n_bx[BX_W-1:0];
            r5_by  <= n_by[BY_W-1:0];
            r5_x   <= r4_x;
            r5_y   <= r4_y;
            r5_f9  <= r4_f9;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: color of the pixel
    // ------------------------------------------------------------------
    logic [31:0]        r6_word;
    atpg_pkg::t_pattern r6_pat;
    logic [31:0]        n_word;
    logic [SX_W-1:0]    x_s, bx_s, bx_end;
    logic [SY_W-1:0]    y_s, by_s, by_end;
    logic               in_box;
    logic [8:0]         grad_sum;
    logic [7:0]         xor_v;
    logic [7:0]         red, green, blue;

    assign x_s    = SX_W'(r5_x);
    assign bx_s   = SX_W'(r5_bx);
    assign bx_end = bx_s + SX_W'(r_box_width);
    assign y_s    = SY_W'(r5_y);
    assign by_s   = SY_W'(r5_by);
    assign by_end = by_s + SY_W'(r_box_height);
    assign in_box = (x_s >= bx_s) && (x_s < bx_end) && (y_s >= by_s) && (y_s < by_end);

    assign grad_sum = 9'(r5_x) + 9'(r5_y) + r5_f9;
    assign xor_v    = r5_x[7:0] ^ r5_y ^ r5_f9[7:0];

    always_comb begin
        case (r5_pat)
            atpg_pkg::PAT_GRADIENT: begin
                red   = r5_x[7:0] + r5_f9[7:0];
                green = {r5_y[6:0], 1'b0};
                blue  = grad_sum[8:1];
            end
            atpg_pkg::PAT_XOR: begin
                red   = xor_v;
                green = {1'b0, xor_v[7:1]};
                blue  = {xor_v[6:0], 1'b0};
            end
            atpg_pkg::PAT_BOX: begin
                if (in_box) begin
                    red   = atpg_pkg::CHAN_FULL;
                    green = atpg_pkg::CHAN_FULL;
                    blue  = atpg_pkg::CHAN_ZERO;
                end else begin
                    red   = atpg_pkg::CHAN_ZERO;
                    green = atpg_pkg::CHAN_ZERO;
                    blue  = {2'b00, r5_y[5:0]};
                end
            end
            default: begin
                red   = atpg_pkg::CHAN_ZERO;
                green = atpg_pkg::CHAN_ZERO;
                blue  = atpg_pkg::CHAN_ZERO;
            end
        endcase
    end

    assign n_word = {atpg_pkg::ALPHA_OPAQUE, blue, green, red};

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r6_word <= n_word;
            r6_pat  <= r5_pat;
        end
    end

    assign o_rgba_word     = r6_word;
    assign o_pattern_index = r6_pat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ATPG_ASSERT(a_full_pipe_stalls, i_clk, i_rst_n, (r_valid == {NS{1'b1}}) && i_stall |-> o_stall, "full pipeline did not stall input")
    `ATPG_ASSERT(a_accept_fills, i_clk, i_rst_n, i_valid && !o_stall |=> r_valid[0], "accepted word lost at first stage")
    `ATPG_ASSERT(a_xor_green, i_clk, i_rst_n, o_valid && (o_pattern_index == atpg_pkg::PAT_XOR) |-> (o_rgba_word[15:8] == {1'b0, o_rgba_word[7:1]}), "xor green is not red shifted")
    `ATPG_ASSERT(a_box_colors, i_clk, i_rst_n, o_valid && (o_pattern_index == atpg_pkg::PAT_BOX) && (o_rgba_word[7:0] != atpg_pkg::CHAN_ZERO) |-> (o_rgba_word[23:16] == atpg_pkg::CHAN_ZERO), "box pixel has blue")
    `ATPG_ASSERT_ALWAYS(a_ready_high, i_clk, pready, "config port not ready")

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the animated test pattern generator: pixel words go
// in with random gaps, color words come out under random stalls and are
// compared field by field against a predicted color, over several box sizes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int SCREEN_W       = 320;
    localparam int SCREEN_H       = 200;
    localparam int FRAMES_PER_PAT = 90;
    localparam int PIPE_DEPTH     = 6;
    localparam int DRAIN_CYCLES   = 4 * PIPE_DEPTH;
    localparam int RANDOM_PHASES  = 5;
    localparam int RANDOM_WORDS   = 180;
    localparam int LIMIT_NS       = 1_000_000;

    localparam logic [atpg_pkg::ADDR_W-1:0] ADDR_BOX_WIDTH  =
        {atpg_pkg::REG_BOX_WIDTH, 2'b00};
    localparam logic [atpg_pkg::ADDR_W-1:0] ADDR_BOX_HEIGHT =
        {atpg_pkg::REG_BOX_HEIGHT, 2'b00};

    typedef struct packed {
        logic [31:0]        rgba;
        atpg_pkg::t_pattern pattern;
    } t_pixel_color;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [atpg_pkg::NUM_W-1:0]    i_frame_number = '0;
    logic [atpg_pkg::PIX_X_W-1:0]  i_pixel_x      = '0;
    logic [atpg_pkg::PIX_Y_W-1:0]  i_pixel_y      = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [31:0]                   o_rgba_word;
    logic [1:0]                    o_pattern_index;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [atpg_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // mirrored box size registers
    int unsigned box_w_cfg = atpg_pkg::BOX_WIDTH_RST;
    int unsigned box_h_cfg = atpg_pkg::BOX_HEIGHT_RST;

    t_pixel_color color_queue[$];
    t_pixel_color color_due;
    int           error_count = 0;
    bit           tx_quiet = 1'b0;
    bit           rx_quiet = 1'b0;
    int           rx_hold = 0;

    animated_test_pattern_generator_top #(
        .SCREEN_WIDTH      (SCREEN_W),
        .SCREEN_HEIGHT     (SCREEN_H),
        .FRAMES_PER_PATTERN(FRAMES_PER_PAT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_frame_number (i_frame_number),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rgba_word    (o_rgba_word),
        .o_pattern_index(o_pattern_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // position folded back at the screen edge
    function automatic int unsigned bounce(input int unsigned pos, input int unsigned span);
        int unsigned p;
        p = pos % (2 * span);
        if (p >= span) begin
            p = 2 * span - p;
        end
        return p;
    endfunction

    // predicted color of one pixel under the current box size
    function automatic t_pixel_color paint_pixel(input logic [atpg_pkg::NUM_W-1:0] frame,
                                                 input logic [atpg_pkg::PIX_X_W-1:0] px,
                                                 input logic [atpg_pkg::PIX_Y_W-1:0] py);
        int unsigned  f, x, y, bx, by, v;
        logic [7:0]   red, green, blue;
        t_pixel_color c;
        f = frame;
        x = px;
        y = py;
        c.pattern = atpg_pkg::t_pattern'(2'((f / FRAMES_PER_PAT) % 3));
        case (c.pattern)
            atpg_pkg::PAT_GRADIENT: begin
                red   = 8'(x + f);
                green = 8'(2 * y);
                blue  = 8'((x + y + f) >> 1);
            end
            atpg_pkg::PAT_XOR: begin
                v     = (x ^ y ^ f) & 32'hFF;
                red   = 8'(v);
                green = 8'(v >> 1);
                blue  = 8'(v << 1);
            end
            default: begin
                bx = bounce(f, SCREEN_W);
                by = bounce((3 * f) / 4, SCREEN_H);
                if (x >= bx && x < bx + box_w_cfg && y >= by && y < by + box_h_cfg) begin
                    red   = atpg_pkg::CHAN_FULL;
                    green = atpg_pkg::CHAN_FULL;
                    blue  = atpg_pkg::CHAN_ZERO;
                end else begin
                    red   = atpg_pkg::CHAN_ZERO;
                    green = atpg_pkg::CHAN_ZERO;
                    blue  = 8'(y & 32'h3F);
                end
            end
        endcase
        c.rgba = {atpg_pkg::ALPHA_OPAQUE, blue, green, red};
        return c;
    endfunction

    // idle length before a word: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // random output stalls, short bursts and a few long holds
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            i_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b1;
            rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 2);
        end
    end

    // compare each accepted color word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (color_queue.size() == 0) begin
                $error("color word with none predicted: rgba_word %08h", o_rgba_word);
                error_count++;
            end else begin
                color_due = color_queue.pop_front();
                if (o_rgba_word !== color_due.rgba) begin
                    $error("rgba_word mismatch: expected %08h, actual %08h",
                           color_due.rgba, o_rgba_word);
                    error_count++;
                end
                if (o_pattern_index !== color_due.pattern) begin
                    $error("pattern_index mismatch: expected %0d, actual %0d",
                           color_due.pattern, o_pattern_index);
                    error_count++;
                end
            end
        end
    end

    // one pixel word, held until accepted
    task automatic send_pixel(input logic [atpg_pkg::NUM_W-1:0] frame,
                              input logic [atpg_pkg::PIX_X_W-1:0] px,
                              input logic [atpg_pkg::PIX_Y_W-1:0] py);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_frame_number <= frame;
        i_pixel_x      <= px;
        i_pixel_y      <= py;
        do @(posedge i_clk); while (o_stall);
        color_queue.push_back(paint_pixel(frame, px, py));
    endtask

    // pixel near the bouncing box of a box-pattern frame
    task automatic send_near_box();
        logic [atpg_pkg::NUM_W-1:0] frame;
        int                         bx, by, xp, yp;
        frame = atpg_pkg::NUM_W'($urandom_range(0, 62136) * 270 + 180
                                 + $urandom_range(0, 89));
        bx = bounce(frame, SCREEN_W);
        by = bounce((3 * int'(frame)) / 4, SCREEN_H);
        xp = bx + $urandom_range(0, box_w_cfg + 3) - 2;
        yp = by + $urandom_range(0, box_h_cfg + 3) - 2;
        if (xp < 0) xp = 0;
        if (yp < 0) yp = 0;
        send_pixel(frame, atpg_pkg::PIX_X_W'(xp), atpg_pkg::PIX_Y_W'(yp));
    endtask

    // run of neighboring pixels along one line of one frame
    task automatic send_scan_run(input int len);
        logic [atpg_pkg::NUM_W-1:0]   frame;
        logic [atpg_pkg::PIX_X_W-1:0] x0;
        logic [atpg_pkg::PIX_Y_W-1:0] y0;
        frame = atpg_pkg::NUM_W'($urandom_range(0, 24'hFFFFFF));
        x0    = atpg_pkg::PIX_X_W'($urandom_range(0, SCREEN_W - 1));
        y0    = atpg_pkg::PIX_Y_W'($urandom_range(0, SCREEN_H - 1));
        for (int i = 0; i < len; i++) begin
            send_pixel(frame, x0 + atpg_pkg::PIX_X_W'(i), y0);
        end
    endtask

    // let the pipeline empty out before touching the registers
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (color_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [atpg_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [atpg_pkg::ADDR_W-1:0] addr,
                            output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read both box registers back against the mirror
    task automatic check_box_regs();
        logic [31:0] rd;
        apb_read(ADDR_BOX_WIDTH, rd);
        if (rd !== 32'(box_w_cfg)) begin
            $error("box_width readback mismatch: expected %0d, actual %0d", box_w_cfg, rd);
            error_count++;
        end
        apb_read(ADDR_BOX_HEIGHT, rd);
        if (rd !== 32'(box_h_cfg)) begin
            $error("box_height readback mismatch: expected %0d, actual %0d", box_h_cfg, rd);
            error_count++;
        end
    endtask

    // new box size; upper data bits may carry junk that must be dropped
    task automatic set_box_size(input int unsigned w, input int unsigned h, input bit junk);
        logic [31:0] hi_w, hi_h;
        hi_w = junk ? ($urandom() & ~32'h1FF) : '0;
        hi_h = junk ? ($urandom() & ~32'hFF) : '0;
        apb_write(ADDR_BOX_WIDTH, hi_w | 32'(w));
        apb_write(ADDR_BOX_HEIGHT, hi_h | 32'(h));
        box_w_cfg = w & 32'h1FF;
        box_h_cfg = h & 32'hFF;
        check_box_regs();
    endtask

    task automatic test_register_reset();
        check_box_regs();
    endtask

    // field extremes, pattern boundaries, box edges, off-screen pixels
    task automatic test_directed_pixels();
        tx_quiet = 1'b0;
        send_pixel(24'd0, 9'd0, 8'd0);
        send_pixel(24'd0, 9'd319, 8'd199);
        send_pixel(24'd0, 9'd511, 8'd255);
        send_pixel(24'd89, 9'd511, 8'd255);
        send_pixel(24'd90, 9'd0, 8'd0);
        send_pixel(24'd90, 9'd511, 8'd255);
        send_pixel(24'd179, 9'd170, 8'd85);
        send_pixel(24'd180, 9'd180, 8'd135);
        send_pixel(24'd180, 9'd219, 8'd164);
        send_pixel(24'd180, 9'd220, 8'd164);
        send_pixel(24'd180, 9'd219, 8'd165);
        send_pixel(24'd180, 9'd179, 8'd135);
        send_pixel(24'd269, 9'd0, 8'd0);
        send_pixel(24'd270, 9'd255, 8'd128);
        // box hanging off the right edge, hit off screen
        send_pixel(24'd1599, 9'd330, 8'd5);
        send_pixel(24'd1599, 9'd318, 8'd1);
        send_pixel(24'hFFFFFF, 9'd0, 8'd0);
        send_pixel(24'hFFFFFF, 9'd511, 8'd255);
        send_pixel(24'hAAAAAA, 9'h155, 8'hAA);
        send_pixel(24'h555555, 9'h0AA, 8'h55);
        wait_drained();
    endtask

    // smallest, screen-sized, empty and widest boxes
    task automatic test_box_extremes();
        int unsigned sizes_w[4] = '{1, 320, 0, 511};
        int unsigned sizes_h[4] = '{1, 200, 0, 255};
        for (int s = 0; s < 4; s++) begin
            set_box_size(sizes_w[s], sizes_h[s], 1'b0);
            for (int i = 0; i < 30; i++) begin
                send_near_box();
            end
            wait_drained();
        end
    endtask

    // random mix of pixels, box hits and scan runs over random box sizes
    task automatic test_random_pixels();
        int sent, r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if ($urandom_range(0, 1) == 0) begin
                set_box_size($urandom_range(1, 320), $urandom_range(1, 200), 1'b1);
            end else begin
                set_box_size($urandom_range(0, 511), $urandom_range(0, 255), 1'b1);
            end
            sent = 0;
            while (sent < RANDOM_WORDS) begin
                if (sent % 60 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    send_pixel(atpg_pkg::NUM_W'($urandom_range(0, 24'hFFFFFF)),
                               atpg_pkg::PIX_X_W'($urandom_range(0, SCREEN_W - 1)),
                               atpg_pkg::PIX_Y_W'($urandom_range(0, SCREEN_H - 1)));
                    sent++;
                end else if (r < 52) begin
                    send_pixel(atpg_pkg::NUM_W'($urandom_range(0, 24'hFFFFFF)),
                               atpg_pkg::PIX_X_W'($urandom()),
                               atpg_pkg::PIX_Y_W'($urandom()));
                    sent++;
                end else if (r < 85) begin
                    send_near_box();
                    sent++;
                end else begin
                    send_scan_run(8);
                    sent += 8;
                end
            end
            wait_drained();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_directed_pixels();
        test_box_extremes();
        test_random_pixels();
        wait_drained();
        if (error_count == 0 && color_queue.size() == 0) begin
            $display("animated_test_pattern_generator_top verification clean");
        end else begin
            $display("animated_test_pattern_generator_top verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("animated_test_pattern_generator_top verification failed");
        $finish;
    end

endmodule
